### sv/mexp_pkg.sv
// Shared types for the modular exponentiation core.
// Holds the controller state encoding, the datapath command set and the
// command and status structs. No dependencies.
package mexp_pkg;

  // Register index of the modulus on the configuration port.
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_SAVE_BASE,
    S_SQ_INIT,
    S_SQ,
    S_SQ_SAVE,
    S_MB_INIT,
    S_MB,
    S_MB_SAVE,
    S_NEXT,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_STEP,
    OP_SAVE_BASE,
    OP_LOAD_SQ,
    OP_LOAD_MB,
    OP_SAVE_R,
    OP_SHIFT_EXP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic exp_msb;
    logic mod_small;
  } mexp_sts_t;

endpackage

### sv/mexp_datapath.sv
// Datapath of the modular exponentiation core: bit-serial modular multiplier,
// exponent shift register, running power and result register.
// Depends on mexp_pkg.
module mexp_datapath #(
  parameter int WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mexp_pkg::mexp_cmd_t   cmd_i,
  input  logic [WIDTH-1:0]      mod_i,
  input  logic [WIDTH-1:0]      base_i,
  input  logic [WIDTH-1:0]      exp_i,
  output mexp_pkg::mexp_sts_t   sts_o,
  output logic [WIDTH-1:0]      result_o
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q;
  logic [WIDTH-1:0] y_q;
  logic [WIDTH-1:0] base_q;
  logic [WIDTH-1:0] r_q;
  logic [WIDTH-1:0] exp_q;
  logic [WIDTH-1:0] result_q;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;
  logic             mod_small;

  // One multiplier step: acc = (2*acc + bit*x) mod m. The sum stays below 3m,
  // so subtracting 2m or m, or nothing, finishes the reduction.
  always_comb begin
    mod1 = {2'b00, mod_i};
    mod2 = {1'b0, mod_i, 1'b0};
    sum  = ({2'b00, acc_q} << 1) + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
    if (sum >= mod2) begin
      acc_d = sum[WIDTH-1:0] - mod2[WIDTH-1:0];
    end else if (sum >= mod1) begin
      acc_d = sum[WIDTH-1:0] - mod1[WIDTH-1:0];
    end else begin
      acc_d = sum[WIDTH-1:0];
    end
  end

  assign mod_small = (mod_i[WIDTH-1:1] == '0);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        // Reducing the base is a multiplication of one by the raw base.
        acc_q <= '0;
        x_q   <= WIDTH'(1);
        y_q   <= base_i;
        exp_q <= exp_i;
      end
      OP_STEP: begin
        acc_q <= acc_d;
        y_q   <= y_q << 1;
      end
      OP_SAVE_BASE: begin
        base_q <= acc_q;
        r_q    <= WIDTH'(1);
      end
      OP_LOAD_SQ: begin
        acc_q <= '0;
        x_q   <= r_q;
        y_q   <= r_q;
      end
      OP_LOAD_MB: begin
        acc_q <= '0;
        x_q   <= r_q;
        y_q   <= base_q;
      end
      OP_SAVE_R: begin
        r_q <= acc_q;
      end
      OP_SHIFT_EXP: begin
        exp_q <= exp_q << 1;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      result_q <= mod_small ? '0 : r_q;
    end
  end

  assign sts_o.exp_msb   = exp_q[WIDTH-1];
  assign sts_o.mod_small = mod_small;
  assign result_o        = result_q;

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_STEP && !mod_small) |=> (acc_q < mod_i))
    else $error("multiplier accumulator not reduced below the modulus");

  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SAVE_BASE && !mod_small) |=> (base_q < mod_i))
    else $error("reduced base not below the modulus");

  a_power_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SAVE_R && !mod_small) |=> (r_q < mod_i))
    else $error("running power not below the modulus");

endmodule

### sv/mexp_ctrl.sv
// Sequencer of the modular exponentiation core: walks the exponent bits,
// counts multiplier steps and owns the input and output handshakes.
// Depends on mexp_pkg.
module mexp_ctrl #(
  parameter int WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mexp_pkg::mexp_sts_t   sts_i,
  output mexp_pkg::mexp_cmd_t   cmd_o
);
  import mexp_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  state_e        state_q, state_d;
  logic [CW-1:0] step_cnt_q, step_cnt_d;
  logic [CW-1:0] bit_cnt_q, bit_cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          step_last;
  logic          bit_last;

  assign step_last = (step_cnt_q == CW'(WIDTH - 1));
  assign bit_last  = (bit_cnt_q == CW'(WIDTH - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.mod_small ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (step_last) begin
          state_d = S_SAVE_BASE;
        end
      end
      S_SAVE_BASE: state_d = S_SQ_INIT;
      S_SQ_INIT:   state_d = S_SQ;
      S_SQ: begin
        if (step_last) begin
          state_d = S_SQ_SAVE;
        end
      end
      S_SQ_SAVE: begin
        state_d = sts_i.exp_msb ? S_MB_INIT : S_NEXT;
      end
      S_MB_INIT:   state_d = S_MB;
      S_MB: begin
        if (step_last) begin
          state_d = S_MB_SAVE;
        end
      end
      S_MB_SAVE:   state_d = S_NEXT;
      S_NEXT: begin
        state_d = bit_last ? S_FINISH : S_SQ_INIT;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o.op       = OP_IDLE;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      S_REDUCE, S_SQ, S_MB: cmd_o.op = OP_STEP;
      S_SAVE_BASE:          cmd_o.op = OP_SAVE_BASE;
      S_SQ_INIT:            cmd_o.op = OP_LOAD_SQ;
      S_MB_INIT:            cmd_o.op = OP_LOAD_MB;
      S_SQ_SAVE, S_MB_SAVE: cmd_o.op = OP_SAVE_R;
      S_NEXT:               cmd_o.op = OP_SHIFT_EXP;
      S_FINISH: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Counters and output valid.
  always_comb begin
    if (state_q == S_REDUCE || state_q == S_SQ || state_q == S_MB) begin
      step_cnt_d = step_cnt_q + CW'(1);
    end else begin
      step_cnt_d = '0;
    end
    if (state_q == S_IDLE) begin
      bit_cnt_d = '0;
    end else if (state_q == S_NEXT) begin
      bit_cnt_d = bit_cnt_q + CW'(1);
    end else begin
      bit_cnt_d = bit_cnt_q;
    end
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_cnt_q  <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_cnt_q  <= step_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded over a waiting result");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_FINISH))
    else $error("result raised outside the finish state");

endmodule

### sv/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: configuration registers and
// the controller and datapath instances.
// Depends on mexp_pkg, mexp_ctrl and mexp_datapath.
//
// Each input beat carries a base and an exponent; the core returns one result
// beat holding base raised to exponent modulo the configured modulus. The base
// is first reduced modulo the modulus, then the exponent is scanned from its
// most significant bit down, squaring the running power at every bit and
// multiplying by the reduced base at every set bit. Every modular product is
// formed by a single bit-serial multiplier that handles one multiplier bit per
// cycle, with a load before and a save after each product. With a modulus
// below two the answer is zero. One item is in flight at a time, but a
// finished result waits in its own register so that the next item can be
// accepted before it is taken. The modulus sits at byte address 0 of the
// configuration port and resets to two; it must only be changed while the
// core is idle.
module modular_exponentiation_core #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] base_value_i,
  input  logic [31:0] exponent_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] power_result_o
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] mod_q, mod_d;
  logic [63:0]      wdata_ext;
  logic [63:0]      mod_ext;
  logic [63:0]      base_ext;
  logic [63:0]      exp_ext;
  logic [63:0]      result_ext;
  logic [WIDTH-1:0] result_w;
  logic             cfg_write;
  mexp_cmd_t        cmd;
  mexp_sts_t        sts;

  // Fields are 32 bits wide on the ports. The internal width keeps only the
  // low WIDTH bits of every field, and pads with zeros when WIDTH is larger.
  assign wdata_ext  = 64'(pwdata);
  assign base_ext   = 64'(base_value_i);
  assign exp_ext    = 64'(exponent_i);
  assign mod_ext    = 64'(mod_q);
  assign result_ext = 64'(result_w);

  // A write lands in the access phase. Only the address bit above the byte
  // offset selects a register, so any address past the modulus is ignored.
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
  assign mod_d     = cfg_write ? wdata_ext[WIDTH-1:0] : mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WIDTH'(2);
    end else begin
      mod_q <= mod_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODULUS) ? mod_ext[31:0] : '0;

  mexp_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .mod_i    (mod_q),
    .base_i   (base_ext[WIDTH-1:0]),
    .exp_i    (exp_ext[WIDTH-1:0]),
    .sts_o    (sts),
    .result_o (result_w)
  );

  assign power_result_o = result_ext[31:0];

endmodule

### tb/modular_exponentiation_core_tb.sv
`timescale 1ns / 100ps
// Testbench for modular_exponentiation_core: a power scoreboard class and the
// driving tasks that feed operand beats and program the modulus over the APB port.
// Depends on mexp_pkg and the core itself.

// Keeps its own copy of the modulus and predicts base ** exponent mod modulus for
// every operand beat the core takes. It then matches result beats in order.
class power_scoreboard;

  typedef struct {
    logic [31:0] base_value;
    logic [31:0] exponent;
    logic [31:0] power_result;
  } power_job_t;

  logic [31:0] modulus;
  power_job_t  pending_powers[$];
  int          error_count;

  function new();
    modulus     = 32'd2;
    error_count = 0;
  endfunction

  function void set_modulus(logic [31:0] value);
    modulus = value;
  endfunction

  function int pending();
    return pending_powers.size();
  endfunction

  task report(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Square and multiply from the top exponent bit down. The products fit in
  // 64 bits because both factors are already below the modulus.
  function logic [31:0] predict_power(logic [31:0] base_value, logic [31:0] exponent);
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] r;
    if (modulus < 32'd2) begin
      return 32'd0;
    end
    m = {32'd0, modulus};
    b = {32'd0, base_value} % m;
    r = 64'd1;
    for (int i = 31; i >= 0; i--) begin
      r = (r * r) % m;
      if (exponent[i]) begin
        r = (r * b) % m;
      end
    end
    return r[31:0];
  endfunction

  function void note_operands(logic [31:0] base_value, logic [31:0] exponent);
    power_job_t job;
    job.base_value   = base_value;
    job.exponent     = exponent;
    job.power_result = predict_power(base_value, exponent);
    pending_powers.push_back(job);
  endfunction

  task check_power(logic [31:0] power_result);
    power_job_t job;
    if (pending_powers.size() == 0) begin
      report($sformatf("result %h arrived with nothing pending", power_result));
    end else begin
      job = pending_powers.pop_front();
      if (power_result !== job.power_result) begin
        report($sformatf("%h ** %h mod %h: got %h, want %h", job.base_value,
                         job.exponent, modulus, power_result, job.power_result));
      end
    end
  endtask

  task check_drained();
    power_job_t job;
    while (pending_powers.size() != 0) begin
      job = pending_powers.pop_front();
      report($sformatf("no result for %h ** %h, want %h", job.base_value,
                       job.exponent, job.power_result));
    end
  endtask

endclass

module modular_exponentiation_core_tb;
  import mexp_pkg::*;

  // The slowest item is one with all 32 exponent bits set.
  // On top of that an item may see the longest input gap and the longest output
  // stall. The whole budget is then taken three times over.
  localparam longint ITEM_BUDGET      = 330;
  localparam longint WORST_ITEM_CYCLES = 2243 + 2500 + 3000 + 16;
  localparam longint CYCLE_LIMIT       = ITEM_BUDGET * WORST_ITEM_CYCLES * 3;
  localparam int     RANDOM_ITEMS      = 272;
  localparam int     RANDOM_PHASES     = 8;
  localparam logic [2:0] MODULUS_ADDR  = 3'(4 * REG_MODULUS);

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] base_value_i;
  logic [31:0] exponent_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] power_result_o;

  power_scoreboard sb;

  // While this is set neither side idles, so for a while beats go as fast as the core takes them.
  logic   steady;
  longint cycle_count;

  modular_exponentiation_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .power_result_o(power_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  // Watchdog. A run that hangs anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every result beat is checked at the edge that accepts it. Inputs change
  // only on falling edges, so the values seen here are settled.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_power(power_result_o);
    end
  end

  // The receiver drops ready on about one cycle in five. Now and then it stalls
  // for a long stretch instead, so a finished result waits in the output
  // register while the next item is being worked on.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!steady && $urandom_range(0, 7999) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(200, 3000)) @(negedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Raise valid with a fresh operand pair and hold it until the core takes the beat.
  task automatic send_operands(logic [31:0] base_value, logic [31:0] exponent);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    base_value_i <= base_value;
    exponent_i   <= exponent;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operands(base_value, exponent);
  endtask

  // Drop valid for a number of cycles.
  task automatic pause_input(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // The sender idles before about one beat in five. Most gaps are short, but
  // some are long enough to let the core finish and sit idle for a while.
  task automatic feed(logic [31:0] base_value, logic [31:0] exponent);
    if (!steady && $urandom_range(0, 99) < 20) begin
      if ($urandom_range(0, 9) == 0) begin
        pause_input($urandom_range(50, 2500));
      end else begin
        pause_input($urandom_range(1, 12));
      end
    end
    send_operands(base_value, exponent);
  endtask

  // Stop sending and wait until every predicted result has come back. Each
  // item gives exactly one result, so the core is idle once this returns.
  task automatic drain_results();
    pause_input(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the modulus, then read it back in a second transfer right after.
  task automatic program_modulus(logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODULUS_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_modulus(value);
    if (readback !== value) begin
      sb.report($sformatf("modulus read back as %h after writing %h", readback, value));
    end
  endtask

  function automatic logic [31:0] pick_modulus(int phase);
    logic [31:0] m;
    case (phase)
      0:       m = $urandom | 32'h8000_0000;
      1:       m = $urandom_range(2, 300);
      2:       m = 32'hFFFF_FFFF;
      3:       m = $urandom_range(2, 65535);
      4:       m = 32'd3;
      5:       m = 32'h7FFF_FFFF;
      default: m = $urandom;
    endcase
    if (m < 32'd2) begin
      m = 32'd2;
    end
    return m;
  endfunction

  // Bases near the modulus and its multiples stress the initial reduction.
  function automatic logic [31:0] pick_base(logic [31:0] m);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return m - 32'd1;
      2:       return m;
      3:       return m * $urandom_range(2, 9) + $urandom_range(0, 3);
      4:       return $urandom_range(0, 15);
      5:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd1 << $urandom_range(0, 31);
      4:       return $urandom_range(2, 64);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] m;
    int          item;
    sb           = new();
    steady       = 1'b0;
    cycle_count  = 0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    base_value_i = '0;
    exponent_i   = '0;
    out_ready_i  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of the modulus is two.
    feed(32'd3, 32'd5);
    feed(32'd0, 32'd0);
    drain_results();

    // Largest modulus, with the extremes of both operands and the zero and one
    // exponent cases.
    program_modulus(32'hFFFF_FFFF);
    feed(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    feed(32'hFFFF_FFFE, 32'd2);
    feed(32'd0, 32'd0);
    feed(32'd0, 32'd1);
    feed(32'h1234_5678, 32'd0);
    feed(32'hFFFF_FFFF, 32'd1);
    feed(32'h8000_0000, 32'd3);
    drain_results();

    // A modulus of one always gives zero.
    program_modulus(32'd1);
    feed(32'd5, 32'd7);
    feed(32'd0, 32'd0);
    drain_results();

    // A modulus of zero cannot reduce anything and gives zero as well.
    program_modulus(32'd0);
    feed(32'hFFFF_FFFF, 32'd1);
    feed(32'd9, 32'd0);
    drain_results();

    // Largest 32-bit prime. A base above the modulus with exponent one must
    // come back reduced.
    program_modulus(32'hFFFF_FFFB);
    feed(32'hFFFF_FFFC, 32'd1);
    feed(32'd2, 32'hFFFF_FFFF);
    feed(32'hFFFF_FFFA, 32'hFFFF_FFFA);
    feed(32'd1, 32'h8000_0000);
    feed(32'd0, 32'd5);
    drain_results();

    // Smallest legal modulus, written explicitly.
    program_modulus(32'd2);
    feed(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    feed(32'd2, 32'd1);
    drain_results();

    // Random part: a fresh modulus per phase, random operands within it.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      m = pick_modulus(phase);
      program_modulus(m);
      for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
        item   = phase * (RANDOM_ITEMS / RANDOM_PHASES) + k;
        steady = (item >= 80) && (item < 140);
        // Now and then the sender holds off until the core has emptied.
        if (!steady && $urandom_range(0, 19) == 0) begin
          drain_results();
        end
        feed(pick_base(m), pick_exponent());
      end
      drain_results();
    end
    steady = 1'b0;

    // One item's worth of extra cycles catches a stray late result beat.
    repeat (2300) @(posedge clk_i);
    sb.check_drained();
    if (sb.error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
